// ===== design/pcc_pkg.sv =====
package pcc_pkg;

  // default sizing of the code table
  localparam int SYMBOLS_DEF      = 16;
  localparam int MAX_CODE_LEN_DEF = 16;

  // fixed field widths
  localparam int FUNC_W       = 2;
  localparam int INDEX_W      = 4;
  localparam int ENTRY_BITS_W = 16;
  localparam int ENTRY_LEN_W  = 5;
  localparam int KIND_W       = 2;
  localparam int COUNT_W      = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_DECODE = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BIT = 2'd0,
    KIND_SYM = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  // summary flags rippling along the row of symbol cells
  typedef struct packed {
    logic seen;
    logic multi;
  } chain_t;

endpackage

// ===== design/pcc_req_if.sv =====
interface pcc_req_if import pcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [INDEX_W-1:0]      symbol_index;
  logic [ENTRY_BITS_W-1:0] entry_bits;
  logic [ENTRY_LEN_W-1:0]  entry_length;
  logic                    bit_in;

  modport source (output valid, func, symbol_index, entry_bits, entry_length, bit_in,
                  input ready);
  modport sink   (input valid, func, symbol_index, entry_bits, entry_length, bit_in,
                  output ready);
endinterface

// ===== design/pcc_rsp_if.sv =====
interface pcc_rsp_if import pcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic               code_bit;
  logic [INDEX_W-1:0] decoded_symbol;
  logic               last;

  modport source (output valid, kind, code_bit, decoded_symbol, last, input ready);
  modport sink   (input valid, kind, code_bit, decoded_symbol, last, output ready);
endinterface

// ===== design/pcc_cfg_if.sv =====
interface pcc_cfg_if import pcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/prefix_code_codec.sv =====
// Prefix code codec with a row of symbol cells.
// Requests arrive on req_i (valid/ready); each carries a function code:
// load writes one table entry and gives no result, encode sends the
// symbol's codeword one bit per result on rsp_o, last on the final bit
// (a symbol at or above the count in use gives one error result instead),
// decode takes one coded bit and gives a result only when the symbol is
// found or no symbol matches. cfg_i writes the symbol count and is always ready.
// A decode result sits in the output register in the cycle after its request.
// Encode loads the codeword into a shift register that emits one bit per
// cycle while the receiver takes results. Every cell compares its codeword
// bit in the same cycle, so decode sustains one coded bit per cycle while
// no codeword is being sent and the receiver does not stall.
// When the receiver stalls, the output register holds its result and
// req_i.ready drops until that result is taken.
// Reset restarts the decoder (all symbols possible, position zero) and
// sets the symbol count to 16; table entries hold nothing until loaded.
module prefix_code_codec import pcc_pkg::*; #(
  parameter int Symbols    = SYMBOLS_DEF,
  parameter int MaxCodeLen = MAX_CODE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcc_req_if.sink     req_i,
  pcc_rsp_if.source   rsp_o,
  pcc_cfg_if.sink     cfg_i
);

  localparam int SymW  = $clog2(Symbols);
  localparam int LenW  = $clog2(MaxCodeLen + 1);
  localparam int CntW  = $clog2(Symbols + 1);

  logic [COUNT_W-1:0]  count_q;
  logic [CntW-1:0]     cnt_use;
  logic [LenW-1:0]     pos_q;
  logic                accept;
  logic                slot_free;
  func_e               func;
  logic [SymW-1:0]     sel;
  logic                load_ok;
  logic                enc_err;
  logic [LenW-1:0]     load_len;
  logic [MaxCodeLen-1:0] load_code;

  logic                do_load;
  logic                do_enc;
  logic                do_dec;
  logic                dec_step;
  logic                dec_restart;

  chain_t              chain  [Symbols+1];
  logic [SymW-1:0]     idx_ch [Symbols+1];
  logic [MaxCodeLen-1:0] code_arr [Symbols];
  logic [LenW-1:0]     len_arr  [Symbols];

  logic                enc_active;
  logic                enc_bit;
  logic                enc_last;
  logic                enc_take;

  logic                out_valid_q;
  kind_e               kind_q;
  logic                bit_q;
  logic [INDEX_W-1:0]  sym_q;
  logic                last_q;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.data;
    end
  end

  // count in use, clamped to 2 .. the table size
  always_comb begin
    if (int'(count_q) < 2) begin
      cnt_use = CntW'(2);
    end else if (int'(count_q) > Symbols) begin
      cnt_use = CntW'(Symbols);
    end else begin
      cnt_use = CntW'(count_q);
    end
  end

  // request handshake
  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !enc_active && slot_free;
  assign accept      = req_i.valid && req_i.ready;
  assign func        = func_e'(req_i.func);
  assign sel         = SymW'(req_i.symbol_index);
  assign load_ok     = int'(req_i.symbol_index) < Symbols;
  assign enc_err     = int'(req_i.symbol_index) >= int'(cnt_use);

  // function decode
  always_comb begin
    do_load = 1'b0;
    do_enc  = 1'b0;
    do_dec  = 1'b0;
    case (func)
      FUNC_LOAD:   do_load = accept && load_ok;
      FUNC_ENCODE: do_enc  = accept;
      FUNC_DECODE: do_dec  = accept;
      default: ;
    endcase
  end

  // load length clamped to 1 .. MaxCodeLen
  always_comb begin
    if (req_i.entry_length == '0) begin
      load_len = LenW'(1);
    end else if (int'(req_i.entry_length) > MaxCodeLen) begin
      load_len = LenW'(MaxCodeLen);
    end else begin
      load_len = LenW'(req_i.entry_length);
    end
  end

  // codeword bits beyond the length are cleared
  for (genvar j = 0; j < MaxCodeLen; j++) begin : g_code
    if (j < ENTRY_BITS_W) begin : g_bit
      assign load_code[j] = req_i.entry_bits[j] && (j < int'(load_len));
    end else begin : g_pad
      assign load_code[j] = 1'b0;
    end
  end

  // row of symbol cells
  assign chain[0]  = '0;
  assign idx_ch[0] = '0;

  for (genvar g = 0; g < Symbols; g++) begin : g_cell
    pcc_cell #(
      .Index      (g),
      .SymW       (SymW),
      .MaxCodeLen (MaxCodeLen)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (do_load && (sel == SymW'(g))),
      .wr_code_i  (load_code),
      .wr_len_i   (load_len),
      .dec_i      (dec_step),
      .restart_i  (dec_restart),
      .eligible_i (CntW'(g) < cnt_use),
      .pos_i      (pos_q),
      .bit_i      (req_i.bit_in),
      .chain_i    (chain[g]),
      .idx_i      (idx_ch[g]),
      .chain_o    (chain[g+1]),
      .idx_o      (idx_ch[g+1]),
      .code_o     (code_arr[g]),
      .len_o      (len_arr[g])
    );
  end

  // decode outcome: more than one left keeps going, else restart
  assign dec_step    = do_dec && chain[Symbols].multi;
  assign dec_restart = do_dec && !chain[Symbols].multi;

  // bit position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (dec_restart) begin
      pos_q <= '0;
    end else if (dec_step && (int'(pos_q) < MaxCodeLen)) begin
      pos_q <= pos_q + LenW'(1);
    end
  end

  // codeword serializer
  assign enc_take = slot_free;

  pcc_encoder #(
    .MaxCodeLen (MaxCodeLen)
  ) u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (do_enc && !enc_err),
    .code_i   (code_arr[sel]),
    .len_i    (len_arr[sel]),
    .take_i   (enc_take),
    .active_o (enc_active),
    .bit_o    (enc_bit),
    .last_o   (enc_last)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= enc_active || (do_enc && enc_err) || dec_restart;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (enc_active) begin
        kind_q <= KIND_BIT;
        bit_q  <= enc_bit;
        sym_q  <= '0;
        last_q <= enc_last;
      end else if (dec_restart && chain[Symbols].seen) begin
        kind_q <= KIND_SYM;
        bit_q  <= 1'b0;
        sym_q  <= INDEX_W'(idx_ch[Symbols]);
        last_q <= 1'b1;
      end else begin
        kind_q <= KIND_ERR;
        bit_q  <= 1'b0;
        sym_q  <= '0;
        last_q <= 1'b1;
      end
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.kind           = kind_q;
  assign rsp_o.code_bit       = bit_q;
  assign rsp_o.decoded_symbol = sym_q;
  assign rsp_o.last           = last_q;

  // no new request while a codeword is being sent
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_active |-> !req_i.ready)
    else $error("request taken while encoder busy");

  // a finished decode restarts at bit position zero
  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_restart |=> (pos_q == '0))
    else $error("decoder did not restart");

  // encode of an unused symbol gives a single error result
  a_enc_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_enc && enc_err) |=> (out_valid_q && (kind_q == KIND_ERR) && last_q && !enc_active))
    else $error("missing encode error result");

endmodule

// ===== design/pcc_cell.sv =====
module pcc_cell import pcc_pkg::*; #(
  parameter int Index      = 0,
  parameter int SymW       = 4,
  parameter int MaxCodeLen = MAX_CODE_LEN_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // table write
  input  logic                                 wr_i,
  input  logic [MaxCodeLen-1:0]                wr_code_i,
  input  logic [$clog2(MaxCodeLen+1)-1:0]      wr_len_i,
  // decode step
  input  logic                                 dec_i,
  input  logic                                 restart_i,
  input  logic                                 eligible_i,
  input  logic [$clog2(MaxCodeLen+1)-1:0]      pos_i,
  input  logic                                 bit_i,
  // neighbor chain
  input  chain_t                               chain_i,
  input  logic [SymW-1:0]                      idx_i,
  output chain_t                               chain_o,
  output logic [SymW-1:0]                      idx_o,
  // table read for encode
  output logic [MaxCodeLen-1:0]                code_o,
  output logic [$clog2(MaxCodeLen+1)-1:0]      len_o
);

  localparam int LenW = $clog2(MaxCodeLen + 1);
  localparam int BitW = $clog2(MaxCodeLen);

  logic [MaxCodeLen-1:0] code_q;
  logic [LenW-1:0]       len_q;
  logic                  alive_q;
  logic                  keep;

  // table entry storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      code_q <= wr_code_i;
      len_q  <= wr_len_i;
    end
  end

  // symbol survives if its codeword has the same bit at this position
  always_comb begin
    keep = 1'b0;
    if (alive_q && eligible_i && (pos_i < len_q)) begin
      keep = (code_q[pos_i[BitW-1:0]] == bit_i);
    end
  end

  // still-possible flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b1;
    end else if (restart_i) begin
      alive_q <= 1'b1;
    end else if (dec_i) begin
      alive_q <= keep;
    end
  end

  // fold this cell into the running summary
  assign chain_o.seen  = chain_i.seen | keep;
  assign chain_o.multi = chain_i.multi | (chain_i.seen & keep);
  assign idx_o         = idx_i | (keep ? SymW'(Index) : '0);

  assign code_o = code_q;
  assign len_o  = len_q;

endmodule

// ===== design/pcc_encoder.sv =====
module pcc_encoder import pcc_pkg::*; #(
  parameter int MaxCodeLen = MAX_CODE_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [MaxCodeLen-1:0]           code_i,
  input  logic [$clog2(MaxCodeLen+1)-1:0] len_i,
  input  logic                            take_i,
  output logic                            active_o,
  output logic                            bit_o,
  output logic                            last_o
);

  localparam int LenW = $clog2(MaxCodeLen + 1);

  logic [MaxCodeLen-1:0] shift_q;
  logic [LenW-1:0]       rem_q;
  logic                  active_q;
  logic                  last_bit;

  assign last_bit = (rem_q <= LenW'(1));

  // codeword shifter, first bit in the low end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= code_i;
      rem_q   <= len_i;
    end else if (active_q && take_i) begin
      shift_q <= shift_q >> 1;
      rem_q   <= rem_q - LenW'(1);
    end
  end

  // busy while bits remain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (start_i) begin
      active_q <= 1'b1;
    end else if (active_q && take_i && last_bit) begin
      active_q <= 1'b0;
    end
  end

  assign active_o = active_q;
  assign bit_o    = shift_q[0];
  assign last_o   = last_bit;

endmodule

// ===== dv/tb_prefix_code_codec.sv =====
`timescale 1ns / 1ps

module tb_prefix_code_codec;
  import pcc_pkg::*;

  localparam int SYMS            = SYMBOLS_DEF;
  localparam int MAX_LEN         = MAX_CODE_LEN_DEF;
  localparam int TOTAL_ITEMS     = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 3000;

  // function code the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [INDEX_W-1:0]      idx;
    logic [ENTRY_BITS_W-1:0] bits;
    logic [ENTRY_LEN_W-1:0]  len;
    logic                    bit_in;
  } codec_req_t;

  typedef struct packed {
    kind_e              kind;
    logic               code_bit;
    logic [INDEX_W-1:0] sym;
    logic               last;
  } codec_res_t;

  typedef struct {
    bit                 is_cfg;
    logic [COUNT_W-1:0] count_val;
    codec_req_t         rq;
    bit                 typed;
    codec_res_t         want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pcc_req_if req_if ();
  pcc_rsp_if rsp_if ();
  pcc_cfg_if cfg_if ();

  prefix_code_codec uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the code table and decoder state
  logic [ENTRY_BITS_W-1:0] tbl_code [SYMS];
  logic [ENTRY_LEN_W-1:0]  tbl_len  [SYMS];
  logic [SYMS-1:0]         alive_q;
  logic [ENTRY_LEN_W-1:0]  pos_q;
  logic [COUNT_W-1:0]      count_q;

  codec_res_t step_res [$];
  codec_res_t pending_results [$];
  stim_row_t  stim_rows [$];

  // scratch code set for one phase
  logic [ENTRY_BITS_W-1:0] gen_code [SYMS];
  logic [ENTRY_LEN_W-1:0]  gen_len  [SYMS];
  int perm [SYMS];

  int err_count;
  int items_sent;
  int quiet_cycles;
  bit calm_phase;
  bit hold_off_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_err(input string what);
    err_count++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic logic [15:0] low_mask(input int n);
    logic [31:0] t;
    t = (32'd1 << n) - 32'd1;
    return t[15:0];
  endfunction

  function automatic int count_in_range(input logic [COUNT_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > SYMS) return SYMS;
    return int'(raw);
  endfunction

  function automatic codec_res_t mk_res(input kind_e k, input logic cb,
                                        input logic [INDEX_W-1:0] s, input logic l);
    codec_res_t r;
    r.kind     = k;
    r.code_bit = cb;
    r.sym      = s;
    r.last     = l;
    return r;
  endfunction

  // expected results of one request, state updated in place
  function automatic void codec_predict(input codec_req_t rq);
    int cnt;
    int i;
    int n;
    int found;
    logic [ENTRY_LEN_W-1:0] ln;
    logic [SYMS-1:0] live;
    step_res.delete();
    cnt = count_in_range(count_q);
    found = 0;
    case (rq.func)
      FUNC_LOAD: begin
        ln = rq.len;
        if (ln < 1) ln = ENTRY_LEN_W'(1);
        if (ln > MAX_LEN) ln = ENTRY_LEN_W'(MAX_LEN);
        tbl_code[rq.idx] = rq.bits & low_mask(ln);
        tbl_len[rq.idx]  = ln;
      end
      FUNC_ENCODE: begin
        if (rq.idx >= cnt) begin
          step_res.push_back(mk_res(KIND_ERR, 1'b0, '0, 1'b1));
        end else begin
          for (i = 0; i < tbl_len[rq.idx]; i++)
            step_res.push_back(mk_res(KIND_BIT, tbl_code[rq.idx][i], '0,
                                      (i + 1 == tbl_len[rq.idx])));
        end
      end
      FUNC_DECODE: begin
        live = alive_q & low_mask(cnt);
        // drop symbols that are exhausted or disagree at this position
        for (i = 0; i < cnt; i++)
          if (live[i] && (pos_q >= tbl_len[i] || tbl_code[i][pos_q] != rq.bit_in))
            live[i] = 1'b0;
        n = 0;
        for (i = 0; i < cnt; i++)
          if (live[i]) begin
            if (n == 0) found = i;
            n++;
          end
        if (n == 1) begin
          step_res.push_back(mk_res(KIND_SYM, 1'b0, found[INDEX_W-1:0], 1'b1));
          alive_q = '1;
          pos_q   = '0;
        end else if (n == 0) begin
          step_res.push_back(mk_res(KIND_ERR, 1'b0, '0, 1'b1));
          alive_q = '1;
          pos_q   = '0;
        end else begin
          alive_q = live;
          if (pos_q < MAX_LEN) pos_q++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic codec_req_t rand_req(input logic [FUNC_W-1:0] f);
    codec_req_t rq;
    rq.func   = f;
    rq.idx    = INDEX_W'($urandom_range(0, 15));
    rq.bits   = ENTRY_BITS_W'($urandom_range(0, 65535));
    rq.len    = ENTRY_LEN_W'($urandom_range(0, 31));
    rq.bit_in = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // directed table rows
  function automatic void row_cfg(input logic [COUNT_W-1:0] v);
    stim_row_t r;
    r.is_cfg    = 1'b1;
    r.count_val = v;
    r.rq        = '0;
    r.typed     = 1'b0;
    r.want      = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void row_req(input logic [FUNC_W-1:0] f, input logic [3:0] i,
                                  input logic [15:0] b, input logic [4:0] l,
                                  input logic bi);
    stim_row_t r;
    r.is_cfg       = 1'b0;
    r.count_val    = '0;
    r.rq.func      = f;
    r.rq.idx       = i;
    r.rq.bits      = b;
    r.rq.len       = l;
    r.rq.bit_in    = bi;
    r.typed        = 1'b0;
    r.want         = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void row_want(input logic [FUNC_W-1:0] f, input logic [3:0] i,
                                   input logic [15:0] b, input logic [4:0] l,
                                   input logic bi, input kind_e k, input logic cb,
                                   input logic [3:0] s);
    int last_row;
    row_req(f, i, b, l, bi);
    last_row = stim_rows.size() - 1;
    stim_rows[last_row].typed = 1'b1;
    stim_rows[last_row].want  = mk_res(k, cb, s, 1'b1);
  endfunction

  // one request on req_if, then its expected results are queued
  task automatic send_req(input codec_req_t rq, input bit typed, input codec_res_t want);
    int k;
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.func         <= rq.func;
    req_if.symbol_index <= rq.idx;
    req_if.entry_bits   <= rq.bits;
    req_if.entry_length <= rq.len;
    req_if.bit_in       <= rq.bit_in;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    items_sent++;
    codec_predict(rq);
    if (typed) pending_results.push_back(want);
    else for (k = 0; k < step_res.size(); k++) pending_results.push_back(step_res[k]);
  endtask

  task automatic sender_pause(input int n);
    @(negedge clk_i) req_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic maybe_pause();
    if (!calm_phase && $urandom_range(0, 99) < 30) sender_pause(pick_gap());
  endtask

  task automatic offer(input codec_req_t rq);
    send_req(rq, 1'b0, '0);
    maybe_pause();
  endtask

  // stop sending until every pending result is out and the block settles
  task automatic drain_all();
    @(negedge clk_i) req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    drain_all();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    count_q = v;
    @(negedge clk_i) cfg_if.valid <= 1'b0;
  endtask

  task automatic shuffle_perm(input int n);
    int i;
    int j;
    int t;
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endtask

  // prefix code by random leaf splitting, or plain noise
  task automatic make_table(input int cnt, input bit noise, input bit skew);
    int nleaf;
    int k;
    int s;
    logic [ENTRY_BITS_W-1:0] lc [SYMS];
    logic [ENTRY_LEN_W-1:0]  ll [SYMS];
    nleaf = 1;
    lc[0] = '0;
    ll[0] = '0;
    while (nleaf < cnt) begin
      if (skew) k = nleaf - 1;
      else k = $urandom_range(0, nleaf - 1);
      while (ll[k] >= MAX_LEN) k = $urandom_range(0, nleaf - 1);
      lc[nleaf] = lc[k] | (16'd1 << ll[k]);
      ll[nleaf] = ll[k] + 5'd1;
      ll[k]     = ll[k] + 5'd1;
      nleaf++;
    end
    shuffle_perm(cnt);
    for (s = 0; s < SYMS; s++) begin
      if (!noise && s < cnt) begin
        gen_code[s] = lc[perm[s]];
        gen_len[s]  = ll[perm[s]];
      end else begin
        gen_code[s] = ENTRY_BITS_W'($urandom_range(0, 65535));
        gen_len[s]  = ENTRY_LEN_W'($urandom_range(1, MAX_LEN));
      end
    end
  endtask

  // load every entry in random order, junk above the length
  task automatic load_table();
    int k;
    int s;
    logic [ENTRY_BITS_W-1:0] m;
    codec_req_t rq;
    shuffle_perm(SYMS);
    for (k = 0; k < SYMS; k++) begin
      s = perm[k];
      rq = rand_req(FUNC_LOAD);
      rq.idx = INDEX_W'(s);
      m = low_mask(gen_len[s]);
      rq.bits = (gen_code[s] & m) | (rq.bits & ~m);
      rq.len = gen_len[s];
      if (gen_len[s] == MAX_LEN && $urandom_range(0, 2) == 0)
        rq.len = ENTRY_LEN_W'($urandom_range(MAX_LEN + 1, 31));
      if (gen_len[s] == 1 && $urandom_range(0, 2) == 0) rq.len = '0;
      offer(rq);
    end
  endtask

  task automatic encode_symbol(input int cnt);
    codec_req_t rq;
    rq = rand_req(FUNC_ENCODE);
    if (cnt < SYMS && $urandom_range(0, 6) == 0)
      rq.idx = INDEX_W'($urandom_range(cnt, SYMS - 1));
    else rq.idx = INDEX_W'($urandom_range(0, cnt - 1));
    offer(rq);
  endtask

  // feed a codeword bit by bit until the decoder answers
  task automatic decode_symbol(input int cnt);
    int s;
    int i;
    bit done;
    codec_req_t rq;
    s = $urandom_range(0, cnt - 1);
    done = 1'b0;
    i = 0;
    while (!done && i < 40) begin
      rq = rand_req(FUNC_DECODE);
      if (i < tbl_len[s] && $urandom_range(0, 24) != 0) rq.bit_in = tbl_code[s][i];
      offer(rq);
      done = (step_res.size() != 0);
      if (!done && $urandom_range(0, 29) == 0) encode_symbol(cnt);
      i++;
    end
  endtask

  task automatic run_phase(input int phase_no);
    logic [COUNT_W-1:0] raw;
    int cnt;
    int n_ops;
    int op;
    int sel;
    codec_req_t rq;
    calm_phase = ($urandom_range(0, 3) == 0);
    case (phase_no)
      0: raw = 5'd31;
      1: raw = 5'd16;
      2: raw = 5'd2;
      3: raw = 5'd1;
      4: raw = 5'd17;
      default: begin
        sel = $urandom_range(0, 99);
        if (sel < 15) raw = COUNT_W'($urandom_range(17, 31));
        else if (sel < 25) raw = COUNT_W'($urandom_range(0, 1));
        else raw = COUNT_W'($urandom_range(2, 16));
      end
    endcase
    write_count(raw);
    cnt = count_in_range(raw);
    make_table(cnt, ($urandom_range(0, 4) == 0), ($urandom_range(0, 3) == 0));
    load_table();
    // long receiver stall while encodes keep coming
    if (phase_no == 1) begin
      hold_off_req = 1'b1;
      repeat (6) encode_symbol(cnt);
    end
    n_ops = $urandom_range(15, 40);
    for (op = 0; op < n_ops; op++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) encode_symbol(cnt);
      else if (sel < 88) decode_symbol(cnt);
      else if (sel < 93) offer(rand_req(FUNC_LOAD));
      else if (sel < 96) offer(rand_req(FUNC_UNUSED));
      else drain_all();
    end
  endtask

  // stimulus
  initial begin : stimulus
    int k;
    int phase_no;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.func         = '0;
    req_if.symbol_index = '0;
    req_if.entry_bits   = '0;
    req_if.entry_length = '0;
    req_if.bit_in       = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    err_count    = 0;
    items_sent   = 0;
    calm_phase   = 1'b0;
    hold_off_req = 1'b0;
    alive_q      = '1;
    pos_q        = '0;
    count_q      = COUNT_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // count of zero clamps to two symbols
    row_cfg(5'd0);
    row_req (FUNC_LOAD,   4'd0,  16'hFFFF, 5'd0,  1'b0);
    row_req (FUNC_LOAD,   4'd1,  16'h0000, 5'd31, 1'b0);
    row_want(FUNC_ENCODE, 4'd0,  16'h0000, 5'd0,  1'b0, KIND_BIT, 1'b1, 4'd0);
    row_req (FUNC_ENCODE, 4'd1,  16'hFFFF, 5'd31, 1'b1);
    row_want(FUNC_ENCODE, 4'd15, 16'h0000, 5'd0,  1'b0, KIND_ERR, 1'b0, 4'd0);
    row_want(FUNC_ENCODE, 4'd2,  16'h0000, 5'd0,  1'b0, KIND_ERR, 1'b0, 4'd0);
    row_want(FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b1, KIND_SYM, 1'b0, 4'd0);
    row_want(FUNC_DECODE, 4'd15, 16'hFFFF, 5'd31, 1'b0, KIND_SYM, 1'b0, 4'd1);
    row_req (FUNC_UNUSED, 4'd15, 16'hFFFF, 5'd31, 1'b1);
    // symbol one now shares the first bit, symbol zero runs out
    row_req (FUNC_LOAD,   4'd1,  16'h0003, 5'd2,  1'b0);
    row_req (FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b1);
    row_want(FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b1, KIND_SYM, 1'b0, 4'd1);
    row_req (FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b1);
    row_want(FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b0, KIND_ERR, 1'b0, 4'd0);
    // count raised mid-decode: symbol two stays out
    row_req (FUNC_LOAD,   4'd2,  16'h0007, 5'd3,  1'b0);
    row_req (FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b1);
    row_cfg(5'd3);
    row_want(FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b1, KIND_SYM, 1'b0, 4'd1);
    row_req (FUNC_LOAD,   4'd1,  16'hA5C3, 5'd16, 1'b1);
    row_req (FUNC_ENCODE, 4'd1,  16'h0000, 5'd0,  1'b0);
    row_req (FUNC_ENCODE, 4'd2,  16'h5A5A, 5'd7,  1'b1);
    row_want(FUNC_ENCODE, 4'd3,  16'h0000, 5'd0,  1'b0, KIND_ERR, 1'b0, 4'd0);
    row_want(FUNC_DECODE, 4'd0,  16'h0000, 5'd0,  1'b0, KIND_ERR, 1'b0, 4'd0);

    for (k = 0; k < stim_rows.size(); k++) begin
      if (stim_rows[k].is_cfg) begin
        write_count(stim_rows[k].count_val);
      end else begin
        send_req(stim_rows[k].rq, stim_rows[k].typed, stim_rows[k].want);
        maybe_pause();
      end
    end

    phase_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      run_phase(phase_no);
      phase_no++;
    end

    drain_all();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver with random gaps and one long hold-off
  initial begin : result_sink
    int gap;
    gap = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        gap--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 99) < 25) gap = pick_gap();
      end
    end
  end

  // compare each result with the oldest pending one
  always @(posedge clk_i) begin : result_check
    codec_res_t w;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_err($sformatf("result with nothing pending, kind %0d", rsp_if.kind));
      end else begin
        w = pending_results.pop_front();
        if (rsp_if.kind !== w.kind)
          report_err($sformatf("kind %0d, want %0d", rsp_if.kind, w.kind));
        if (rsp_if.code_bit !== w.code_bit)
          report_err($sformatf("code_bit %0b, want %0b", rsp_if.code_bit, w.code_bit));
        if (rsp_if.decoded_symbol !== w.sym)
          report_err($sformatf("decoded_symbol %0d, want %0d", rsp_if.decoded_symbol,
                               w.sym));
        if (rsp_if.last !== w.last)
          report_err($sformatf("last %0b, want %0b", rsp_if.last, w.last));
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 ||
          (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout after %0d idle cycles", quiet_cycles);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
